>>> rtl/aros_pkg.sv
// shared types and constants for the advancing rank order statistic unit
`timescale 1ns / 1ps

package aros_pkg;

    localparam int VALUE_W     = 32;
    localparam int RANK_OUT_W  = 9;
    localparam int STATUS_W    = 2;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_PAY_W   = VALUE_W + RANK_OUT_W + STATUS_W;
    localparam int OUT_TDATA_W = ((OUT_PAY_W + 7) / 8) * 8;

    localparam logic KIND_ADD = 1'b0;
    localparam logic KIND_GET = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_UNUSED   = 2'd3;

    typedef struct packed {
        logic ins_en;
        logic cap_load;
        logic cap_shift;
    } aros_ctrl_t;

endpackage

>>> rtl/aros_cell.sv
// one cell of the sorted chain with its read capture stage
`timescale 1ns / 1ps

module aros_cell (
    input  logic                                clk,
    input  aros_pkg::aros_ctrl_t                ctrl,
    input  logic                                occupied,
    input  logic signed [aros_pkg::VALUE_W-1:0] new_val,
    input  logic                                left_gt,
    input  logic signed [aros_pkg::VALUE_W-1:0] left_val,
    input  logic        [aros_pkg::VALUE_W-1:0] right_cap,
    output logic                                gt,
    output logic signed [aros_pkg::VALUE_W-1:0] val,
    output logic        [aros_pkg::VALUE_W-1:0] cap
);
    import aros_pkg::*;

    logic signed [VALUE_W-1:0] val_reg;
    logic signed [VALUE_W-1:0] val_next;
    logic        [VALUE_W-1:0] cap_reg;
    logic        [VALUE_W-1:0] cap_next;

    // empty cells act as larger than anything
    assign gt  = !occupied || (val_reg > new_val);
    assign val = val_reg;
    assign cap = cap_reg;

    always_comb
    begin
        val_next = val_reg;
        if (ctrl.ins_en)
        begin
            if (left_gt)
            begin
                val_next = left_val;
            end
            else if (gt)
            begin
                val_next = new_val;
            end
        end
    end

    always_comb
    begin
        cap_next = cap_reg;
        if (ctrl.cap_load)
        begin
            cap_next = val_reg;
        end
        else if (ctrl.cap_shift)
        begin
            cap_next = right_cap;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        cap_reg <= cap_next;
    end

endmodule

>>> rtl/advancing_rank_order_statistic_unit.sv
// top level: running k-th smallest store built from a chain of sorted cells
//
// input stream s_axis: tuser carries kind (0 add, 1 get), tdata the signed value.
// an add beat inserts the value into the sorted chain and gives
// no result; an add to a full store is dropped and sets a sticky overflow flag.
// a get beat answers the current rank (starting at 1) on m_axis and advances
// the rank when it lies within the stored count.
// a get whose rank is in range copies the chain into the capture stages and
// shifts it toward cell 0 one cell per cycle; no new beat is taken until the
// element reaches cell 0 and has been written to the output register.
// results sit in an output register; the next beat is taken only when that
// register is free or is being emptied, so a stalled receiver holds the input.
// reset empties the store, sets the rank to 1 and clears the overflow flag;
// the cell contents need no clearing.
`timescale 1ns / 1ps

module advancing_rank_order_statistic_unit #(
    parameter int CAPACITY = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [aros_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // value[31:0]
    input  logic                                s_axis_tuser,  // kind
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [aros_pkg::OUT_TDATA_W-1:0]    m_axis_tdata   // element[31:0] rank[40:32]
                                                               // status[42:41] zero pad
);
    import aros_pkg::*;

    localparam int RANK_W = $clog2(CAPACITY + 2);

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

    state_t                  state_reg;
    logic [RANK_W-1:0]       count_reg;
    logic [RANK_W-1:0]       rank_reg;
    logic [RANK_W-1:0]       remain_reg;
    logic                    overflow_reg;
    logic                    out_valid_reg;
    logic [VALUE_W-1:0]      out_element_reg;
    logic [RANK_OUT_W-1:0]   out_rank_reg;
    logic [STATUS_W-1:0]     out_status_reg;

    aros_ctrl_t              ctrl;
    logic                    in_fire;
    logic                    out_free;
    logic                    out_load;
    logic                    full;
    logic                    in_range;
    logic [RANK_W+RANK_OUT_W-1:0] rank_ext;
    logic signed [VALUE_W-1:0] new_val;

    logic                      gt_w  [CAPACITY];
    logic signed [VALUE_W-1:0] val_w [CAPACITY];
    logic        [VALUE_W-1:0] cap_w [CAPACITY];

    assign new_val  = $signed(s_axis_tdata[VALUE_W-1:0]);
    assign out_free = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && out_free;
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign full     = (count_reg == RANK_W'(CAPACITY));
    assign in_range = (rank_reg <= count_reg);
    assign rank_ext = {{RANK_OUT_W{1'b0}}, rank_reg};

    // a new result beat enters the output register this cycle
    assign out_load = ((state_reg == ST_IDLE) && in_fire && (s_axis_tuser == KIND_GET)
                       && !in_range)
                   || ((state_reg == ST_READ) && (remain_reg == '0) && out_free);

    always_comb
    begin
        ctrl.ins_en    = in_fire && (s_axis_tuser == KIND_ADD) && !full;
        ctrl.cap_load  = in_fire && (s_axis_tuser == KIND_GET) && in_range;
        ctrl.cap_shift = (state_reg == ST_READ) && (remain_reg != '0);
    end

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic                      occ;
            logic                      lgt;
            logic signed [VALUE_W-1:0] lval;
            logic        [VALUE_W-1:0] rcap;

            assign occ = (count_reg > RANK_W'(i));
            if (i == 0)
            begin : g_first
                assign lgt  = 1'b0;
                assign lval = new_val;
            end
            else
            begin : g_mid
                assign lgt  = gt_w[i-1];
                assign lval = val_w[i-1];
            end
            if (i == CAPACITY - 1)
            begin : g_last
                assign rcap = '0;
            end
            else
            begin : g_inner
                assign rcap = cap_w[i+1];
            end

            aros_cell u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .occupied  (occ),
                .new_val   (new_val),
                .left_gt   (lgt),
                .left_val  (lval),
                .right_cap (rcap),
                .gt        (gt_w[i]),
                .val       (val_w[i]),
                .cap       (cap_w[i])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rank_reg      <= RANK_W'(1);
            remain_reg    <= '0;
            overflow_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        if (s_axis_tuser == KIND_ADD)
                        begin
                            if (full)
                            begin
                                overflow_reg <= 1'b1;
                            end
                            else
                            begin
                                count_reg <= count_reg + RANK_W'(1);
                            end
                        end
                        else if (in_range)
                        begin
                            remain_reg <= rank_reg - RANK_W'(1);
                            state_reg  <= ST_READ;
                        end
                        else
                        begin
                            out_element_reg <= '0;
                            out_rank_reg    <= rank_ext[RANK_OUT_W-1:0];
                            out_status_reg  <= overflow_reg ? STATUS_OVERFLOW : STATUS_RANGE;
                        end
                    end
                end
                ST_READ:
                begin
                    if (remain_reg != '0)
                    begin
                        remain_reg <= remain_reg - RANK_W'(1);
                    end
                    else if (out_free)
                    begin
                        out_element_reg <= cap_w[0];
                        out_rank_reg    <= rank_ext[RANK_OUT_W-1:0];
                        out_status_reg  <= overflow_reg ? STATUS_OVERFLOW : STATUS_OK;
                        rank_reg        <= rank_reg + RANK_W'(1);
                        state_reg       <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_PAY_W){1'b0}},
                            out_status_reg, out_rank_reg, out_element_reg};

endmodule

>>> rtl/aros_checker.sv
// port-level assertions for the advancing rank order statistic unit
`timescale 1ns / 1ps

module aros_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [aros_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import aros_pkg::*;

    logic [VALUE_W-1:0]    element;
    logic [STATUS_W-1:0]   status;

    assign element = m_axis_tdata[VALUE_W-1:0];
    assign status  = m_axis_tdata[OUT_PAY_W-1:VALUE_W+RANK_OUT_W];

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat dropped or changed while stalled");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> status != STATUS_UNUSED)
        else $error("undefined status code");

    a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && status == STATUS_RANGE |-> element == '0)
        else $error("out-of-range result carries a nonzero element");

    a_overflow_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && status == STATUS_OVERFLOW ##1 m_axis_tvalid
        |-> status == STATUS_OVERFLOW)
        else $error("overflow status cleared without reset");

    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:OUT_PAY_W] == '0)
        else $error("padding bits of result beat not zero");

endmodule

bind advancing_rank_order_statistic_unit aros_checker u_aros_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
